// ----- sv/tgwld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tgwld_pkg;

  localparam int MAX_GRID   = 256;
  localparam int GRID_AW    = $clog2(MAX_GRID);
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SIZE_W     = 9;
  localparam int POS_W      = 8;
  localparam int CNT_W      = 13;
  localparam int LEN_W      = 11;
  localparam int STEP_W     = 8;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 64;

  localparam logic [2:0] ACT_MOVE  = 3'd0;
  localparam logic [2:0] ACT_TURN  = 3'd1;
  localparam logic [2:0] ACT_FLIP  = 3'd2;
  localparam logic [2:0] ACT_CHECK = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_CLR, ST_RD, ST_RESP, ST_DONE,
    ST_LTEST, ST_LISSUE, ST_LCMP, ST_BTEST, ST_BISSUE, ST_BCMP
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic do_move;
    logic do_turn;
    logic clr_row_wr;
    logic clr_apply;
    logic resp;
    logic ld_out;
    logic chk_init;
    logic fold_loop;
    logic fold_branch;
    logic step_j;
    logic len_inc;
    logic b_init;
    logic b_inc;
    logic not_found;
    logic found;
    logic branch_b;
    logic branch_sb;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       clr_last;
    logic       len_ok;
    logic       b_ok;
    logic       match;
    logic       j_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/tgwld_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tgwld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/tgwld_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tgwld_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tgwld_pkg::sts_t sts,
  output tgwld_pkg::cmd_t      cmd
);
  import tgwld_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.clr_row_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.act)
          ACT_MOVE: begin
            cmd.do_move = 1'b1;
            state_next  = ST_RD;
          end
          ACT_TURN: begin
            cmd.do_turn = 1'b1;
            state_next  = ST_RD;
          end
          ACT_CHECK: begin
            cmd.chk_init = 1'b1;
            state_next   = ST_LTEST;
          end
          ACT_CLEAR: state_next = ST_CLR;
          default:   state_next = ST_RD;
        endcase
      end
      ST_CLR: begin
        cmd.clr_row_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_apply = 1'b1;
          state_next    = ST_RD;
        end
      end
      ST_RD: state_next = ST_RESP;
      ST_RESP: begin
        cmd.resp   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_LTEST: begin
        if (sts.len_ok) begin
          cmd.fold_loop = 1'b1;
          state_next    = ST_LISSUE;
        end else begin
          cmd.not_found = 1'b1;
          state_next    = ST_RD;
        end
      end
      ST_LISSUE: state_next = ST_LCMP;
      ST_LCMP: begin
        if (!sts.match) begin
          cmd.len_inc = 1'b1;
          state_next  = ST_LTEST;
        end else if (sts.j_last) begin
          cmd.found  = 1'b1;
          cmd.b_init = 1'b1;
          state_next = ST_BTEST;
        end else begin
          cmd.step_j = 1'b1;
          state_next = ST_LISSUE;
        end
      end
      ST_BTEST: begin
        if (sts.b_ok) begin
          cmd.fold_branch = 1'b1;
          state_next      = ST_BISSUE;
        end else begin
          cmd.branch_sb = 1'b1;
          state_next    = ST_RD;
        end
      end
      ST_BISSUE: state_next = ST_BCMP;
      ST_BCMP: begin
        if (!sts.match) begin
          cmd.b_inc  = 1'b1;
          state_next = ST_BTEST;
        end else if (sts.j_last) begin
          cmd.branch_b = 1'b1;
          state_next   = ST_RD;
        end else begin
          cmd.step_j = 1'b1;
          state_next = ST_BISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/tgwld_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tgwld_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [tgwld_pkg::IN_W-1:0]      in_data,
  input  wire logic                            cfg_we,
  input  wire logic [tgwld_pkg::SIZE_W-1:0]    cfg_wdata,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [tgwld_pkg::OUT_W-1:0]     out_data,
  input  wire tgwld_pkg::cmd_t                 cmd,
  output tgwld_pkg::sts_t                      sts
);
  import tgwld_pkg::*;

  // latched item
  logic [2:0]        act;
  logic [STEP_W-1:0] step;
  logic [1:0]        dir;
  logic              way;
  logic [CNT_W-1:0]  sb;
  logic [LEN_W-1:0]  sl;

  logic [SIZE_W-1:0] size_reg;
  logic [SIZE_W-1:0] eff;
  logic [POS_W-1:0]  pos_col, pos_row;
  logic [1:0]        heading;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  fperiod;
  logic [CNT_W-1:0]  fbranch;
  logic              fflag, err, cell_bit;

  logic [GRID_AW-1:0]  clr_cnt;
  logic [MAX_GRID-1:0] row_rdata, row_wdata;
  logic [GRID_AW-1:0]  row_waddr;
  logic                row_we, bit_now;

  logic [LEN_W-1:0]   len, bound;
  logic [CNT_W-1:0]   p, j, b;
  logic [CNT_W:0]     len5;
  logic [CNT_W:0]     addr_a, addr_b, j_inc;
  logic [CNT_W+1:0]   b_end;
  logic [1:0]         hist_a, hist_b;
  logic               move_err, oob, hist_we;
  logic [SIZE_W-1:0]  col_sum, row_sum;

  always_comb begin
    if (size_reg < SIZE_W'(2))             eff = SIZE_W'(2);
    else if (size_reg > SIZE_W'(MAX_GRID)) eff = SIZE_W'(MAX_GRID);
    else                                   eff = size_reg;
  end

  assign col_sum = {1'b0, pos_col} + {1'b0, step};
  assign row_sum = {1'b0, pos_row} + {1'b0, step};

  always_comb begin
    case (dir)
      DIR_UP:    oob = pos_row < step;
      DIR_RIGHT: oob = col_sum >= eff;
      DIR_DOWN:  oob = row_sum >= eff;
      default:   oob = pos_col < step;
    endcase
  end
  assign move_err = (count >= CNT_W'(HIST_DEPTH)) || oob;
  assign hist_we  = cmd.do_move && !move_err;

  // grid rows, cleared by a row sweep
  assign bit_now   = row_rdata[pos_col];
  assign row_we    = cmd.clr_row_wr || (cmd.resp && act == ACT_FLIP);
  assign row_waddr = cmd.clr_row_wr ? clr_cnt : pos_row;
  assign row_wdata = cmd.clr_row_wr ? '0
                   : (row_rdata ^ (MAX_GRID'(1) << pos_col));

  tgwld_ram #(.WIDTH(MAX_GRID), .DEPTH(MAX_GRID)) u_grid (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (pos_row),
    .rdata (row_rdata)
  );

  // two copies of the history give two reads a cycle
  assign addr_a = {1'b0, p} + {1'b0, j};
  assign addr_b = addr_a + (CNT_W+1)'(len);

  tgwld_ram #(.WIDTH(2), .DEPTH(HIST_DEPTH)) u_hist_a (
    .clk   (clk),
    .we    (hist_we),
    .waddr (count[HIST_AW-1:0]),
    .wdata (dir),
    .raddr (addr_a[HIST_AW-1:0]),
    .rdata (hist_a)
  );

  tgwld_ram #(.WIDTH(2), .DEPTH(HIST_DEPTH)) u_hist_b (
    .clk   (clk),
    .we    (hist_we),
    .waddr (count[HIST_AW-1:0]),
    .wdata (dir),
    .raddr (addr_b[HIST_AW-1:0]),
    .rdata (hist_b)
  );

  assign len5  = {1'b0, len, 2'b00} + (CNT_W+1)'(len);
  assign j_inc = {1'b0, j} + (CNT_W+1)'(1);
  assign b_end = {2'b00, b} + {1'b0, len5};

  assign sts.act      = act;
  assign sts.clr_last = clr_cnt == GRID_AW'(MAX_GRID-1);
  assign sts.len_ok   = (len < bound) && (len5 <= {1'b0, count});
  assign sts.b_ok     = b_end <= (CNT_W+2)'(count);
  assign sts.match    = hist_a == hist_b;
  assign sts.j_last   = j_inc == {1'b0, len, 2'b00};
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg  <= SIZE_W'(MAX_GRID);
      pos_col   <= POS_W'(MAX_GRID/2);
      pos_row   <= POS_W'(MAX_GRID/2);
      heading   <= '0;
      count     <= '0;
      fperiod   <= '0;
      fbranch   <= '0;
      fflag     <= 1'b0;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) size_reg <= cfg_wdata;
      if (cmd.clr_row_wr) clr_cnt <= clr_cnt + GRID_AW'(1);
      if (hist_we) begin
        count <= count + CNT_W'(1);
        case (dir)
          DIR_UP:    pos_row <= pos_row - step;
          DIR_RIGHT: pos_col <= col_sum[POS_W-1:0];
          DIR_DOWN:  pos_row <= row_sum[POS_W-1:0];
          default:   pos_col <= pos_col - step;
        endcase
      end
      if (cmd.do_turn) heading <= way ? heading + 2'd1 : heading - 2'd1;
      if (cmd.clr_apply) begin
        pos_col <= eff[POS_W:1];
        pos_row <= eff[POS_W:1];
        heading <= '0;
        count   <= '0;
      end
      if (cmd.not_found) begin
        fperiod <= len;
        fflag   <= 1'b0;
      end
      if (cmd.found) begin
        fperiod <= len;
        fflag   <= 1'b1;
      end
      if (cmd.branch_b)  fbranch <= b;
      if (cmd.branch_sb) fbranch <= sb;
      if (cmd.ld_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload and search registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act  <= in_data[2:0];
      step <= in_data[10:3];
      dir  <= in_data[12:11];
      way  <= in_data[13];
      sb   <= in_data[26:14];
      sl   <= in_data[37:27];
      err  <= 1'b0;
    end
    if (cmd.do_move) err <= move_err;
    if (cmd.not_found) err <= 1'b1;
    if (cmd.chk_init) begin
      len   <= (sl == '0) ? LEN_W'(1) : sl;
      bound <= (sb <= count) ? LEN_W'((count - sb) >> 2) : '0;
    end
    if (cmd.len_inc) len <= len + LEN_W'(1);
    if (cmd.fold_loop) begin
      p <= count - len5[CNT_W-1:0];
      j <= '0;
    end
    if (cmd.fold_branch) begin
      p <= b;
      j <= '0;
    end
    if (cmd.step_j) j <= j_inc[CNT_W-1:0];
    if (cmd.b_init) b <= sb;
    if (cmd.b_inc)  b <= b + CNT_W'(1);
    if (cmd.resp)   cell_bit <= bit_now ^ (act == ACT_FLIP);
    if (cmd.ld_out) begin
      out_data <= {6'b0, fbranch, fperiod, fflag, count, heading,
                   pos_row, pos_col, cell_bit, err};
    end
  end
endmodule
`default_nettype wire

// ----- sv/turmite_grid_walker_loop_detect_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  beat contents (lowest bit first)
// s_*       in         action, step_length, move_dir, turn_way, start_branch, start_loop
// m_*       out        error, cell_color, ant_x, ant_y, heading, history_count,
//                      loop_found, loop_length, branch_length
// cfg_*     in         grid_size, written whenever cfg_we is high
//
// move, turn, flip and unused codes: the exec, row-read, response and done states lie between input beat
// and result beat, for the registered row read and read-modify-write on the grid memory
// clear: 256 row writes on the grid memory, then the row-read, response and done states
// check loop: each history compare passes an issue and a compare state through the paired history copies
// reset: a sweep of 256 row writes zeroes the grid rows, s_tready stays low meanwhile
// one item at a time; a waiting result beat does not hold up the next input beat
module turmite_grid_walker_loop_detect_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // action, step_length, move_dir, turn_way, start_branch, start_loop
  input  wire logic [tgwld_pkg::IN_W-1:0]         s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // error, cell_color, ant_x, ant_y, heading, history_count, loop_found,
  // loop_length, branch_length
  output logic      [tgwld_pkg::OUT_W-1:0]        m_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [tgwld_pkg::SIZE_W-1:0]       cfg_wdata
);
  import tgwld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the state register only
  tgwld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // grid, history, walker state, search registers and result register
  tgwld_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule
`default_nettype wire
